FILE: hw/rtl/csem_pkg.sv
// package for the counting semaphore with a fifo wait queue
// holds the shared types, the command and status codes, and the field widths
// no dependencies
package csem_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 17;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 17'sd65535;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT   = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_OPEN   = 2'd2,
        CMD_CLOSE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PROCEED  = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_CLOSED   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic            valid;
        status_t         status;
        logic [ID_W-1:0] id;
        logic            last;
    } res_t;

endpackage

FILE: hw/rtl/csem_ram.sv
// generic single-port-write, single-port-read memory with registered read data
// no dependencies
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/csem_ctrl.sv
// semaphore control: count, closed flag, queue pointers and the command sequencer
// depends on csem_pkg; drives the wait queue memory held in csem_ram
module csem_ctrl #(
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF,
    parameter int PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  csem_pkg::cmd_t                in_cmd,
    input  logic [csem_pkg::ID_W-1:0]     in_tid,
    output logic                          in_ready,
    input  logic                          can_load,
    input  logic                          cfg_we,
    input  logic [csem_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                          ram_we,
    output logic [PTR_W-1:0]              ram_waddr,
    output logic [THREAD_ID_BITS-1:0]     ram_wdata,
    output logic                          ram_re,
    output logic [PTR_W-1:0]              ram_raddr,
    input  logic [THREAD_ID_BITS-1:0]     ram_rdata,
    output csem_pkg::res_t                res
);

    import csem_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [CFG_W-1:0]           init_reg;
    logic signed [COUNT_W-1:0]  count_reg, count_next;
    logic                       closed_reg, closed_next;
    logic                       drain_reg, drain_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [PTR_W-1:0]           head_inc;
    logic [PTR_W-1:0]           tail_inc;
    logic                       accept;
    logic                       count_pos;
    logic                       fill_full;
    logic                       fill_one;

    assign head_inc  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && can_load;
    assign accept    = in_valid && in_ready;
    assign count_pos = !count_reg[COUNT_W-1] && (count_reg != '0);
    assign fill_full = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign fill_one  = (fill_reg == FILL_W'(1));

    assign ram_waddr = tail_reg;
    assign ram_wdata = THREAD_ID_BITS'(in_tid);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        drain_next  = drain_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        res.valid   = 1'b0;
        res.status  = ST_PROCEED;
        res.id      = '0;
        res.last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_WAIT:
                        begin
                            res.valid = 1'b1;
                            if (closed_reg)
                            begin
                                res.status = ST_CLOSED;
                            end
                            else if (count_pos)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else if (fill_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                ram_we     = 1'b1;
                                tail_next  = tail_inc;
                                fill_next  = fill_reg + 1'b1;
                                res.status = ST_BLOCKED;
                            end
                        end
                        CMD_SIGNAL:
                        begin
                            if (closed_reg)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_CLOSED;
                            end
                            else if (count_reg[COUNT_W-1] && (fill_reg != '0))
                            begin
                                ram_re     = 1'b1;
                                drain_next = 1'b0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                res.valid = 1'b1;
                                if (count_reg != COUNT_MAX)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_OPEN:
                        begin
                            res.valid   = 1'b1;
                            count_next  = COUNT_W'(init_reg);
                            head_next   = '0;
                            tail_next   = '0;
                            fill_next   = '0;
                            closed_next = 1'b0;
                        end
                        CMD_CLOSE:
                        begin
                            closed_next = 1'b1;
                            if (fill_reg == '0)
                            begin
                                res.valid = 1'b1;
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                drain_next = 1'b1;
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            res.valid = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_RELEASED;
                    res.id     = ID_W'(ram_rdata);
                    res.last   = !drain_reg || fill_one;
                    head_next  = head_inc;
                    fill_next  = fill_reg - 1'b1;
                    if (!drain_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (fill_one)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            init_reg   <= '0;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            drain_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            drain_reg  <= drain_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            if (cfg_we)
            begin
                init_reg <= cfg_wdata;
            end
        end
    end

endmodule

FILE: hw/rtl/counting_semaphore_fifo_waitq_core.sv
// counting semaphore with a fifo of blocked thread ids, top level
// results pass through the output register, in the cycle after the input transfer; a releasing
// signal and a close with waiters first read the wait queue memory, then one waiter per cycle
// while the output is not stalled; input takes one item per cycle likewise, none while releasing
// reset clears count, closed flag, queue pointers and initial_count; queue memory is not cleared
// depends on csem_pkg, csem_ctrl and csem_ram
module counting_semaphore_fifo_waitq_core #(
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // thread_id[7:0]
    input  logic [1:0]                 s_tuser,    // cmd[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,    // released_id[7:0]
    output logic [2:0]                 m_tuser,    // status[2:0]
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [csem_pkg::CFG_W-1:0] cfg_wdata
);

    import csem_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                      can_load;
    logic                      ram_we;
    logic [PTR_W-1:0]          ram_waddr;
    logic [THREAD_ID_BITS-1:0] ram_wdata;
    logic                      ram_re;
    logic [PTR_W-1:0]          ram_raddr;
    logic [THREAD_ID_BITS-1:0] ram_rdata;
    res_t                      res;
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic [ID_W-1:0]           out_id_reg;
    logic                      out_last_reg;

    assign can_load = !out_valid_reg || m_tready;

    csem_ctrl #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .PTR_W          (PTR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_tid    (s_tdata),
        .in_ready  (s_tready),
        .can_load  (can_load),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

    csem_ram #(
        .WIDTH  (THREAD_ID_BITS),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_status_reg <= res.status;
            out_id_reg     <= res.id;
            out_last_reg   <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_nonrelease_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_RELEASED)) |-> m_tlast)
        else $error("non-release result without tlast");

    a_nonrelease_zero_id : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_RELEASED)) |-> (m_tdata == '0))
        else $error("released id set on a non-release result");

    a_open_proceeds : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_OPEN)) |=>
        (m_tvalid && (m_tuser == ST_PROCEED) && m_tlast))
        else $error("open did not answer proceed in the next cycle");

    a_no_accept_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input transfer taken while the output register is stalled");
`endif

endmodule

FILE: test/csem_checker.sv
// checker for the counting semaphore core: watches the command, reply and config channels
// predicts every reply from its own semaphore state and compares it field by field
// depends on csem_pkg
`timescale 1ns / 1ps

module csem_checker #(
    parameter int DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // thread_id[7:0]
    input  logic [1:0]                 s_tuser,    // cmd[1:0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,    // released_id[7:0]
    input  logic [2:0]                 m_tuser,    // status[2:0]
    input  logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [csem_pkg::CFG_W-1:0] cfg_wdata,
    output int                         outstanding,
    output int                         failures,
    output int                         replies_checked,
    output int                         blocked_seen,
    output int                         full_seen,
    output int                         released_seen
);

    import csem_pkg::*;

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] id;
        logic            last;
    } sem_reply_t;

    sem_reply_t                 replies_due[$];
    logic signed [COUNT_W-1:0]  sem_level;
    logic                       sem_closed;
    logic [ID_W-1:0]            waiting_ids[$];
    logic [CFG_W-1:0]           reload_value;

    task automatic push_reply(input status_t st, input logic [ID_W-1:0] id, input logic last);
        sem_reply_t r;
        r.status = st;
        r.id     = id;
        r.last   = last;
        replies_due.push_back(r);
    endtask

    task automatic predict_semaphore(input cmd_t op, input logic [ID_W-1:0] tid);
        logic [ID_W-1:0] id;
        case (op)
            CMD_WAIT:
            begin
                if (sem_closed)
                    push_reply(ST_CLOSED, '0, 1'b1);
                else if (sem_level > 0)
                begin
                    sem_level = COUNT_W'(sem_level - 1);
                    push_reply(ST_PROCEED, '0, 1'b1);
                end
                else if (waiting_ids.size() >= DEPTH)
                begin
                    full_seen++;
                    push_reply(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    sem_level = COUNT_W'(sem_level - 1);
                    waiting_ids.push_back(tid);
                    blocked_seen++;
                    push_reply(ST_BLOCKED, '0, 1'b1);
                end
            end
            CMD_SIGNAL:
            begin
                if (sem_closed)
                    push_reply(ST_CLOSED, '0, 1'b1);
                else if (sem_level < 0 && waiting_ids.size() > 0)
                begin
                    sem_level = COUNT_W'(sem_level + 1);
                    id = waiting_ids.pop_front();
                    released_seen++;
                    push_reply(ST_RELEASED, id, 1'b1);
                end
                else
                begin
                    if (sem_level < COUNT_MAX)
                        sem_level = COUNT_W'(sem_level + 1);
                    push_reply(ST_PROCEED, '0, 1'b1);
                end
            end
            CMD_OPEN:
            begin
                sem_level  = $signed({1'b0, reload_value});
                sem_closed = 1'b0;
                waiting_ids.delete();
                push_reply(ST_PROCEED, '0, 1'b1);
            end
            default:
            begin
                sem_closed = 1'b1;
                if (waiting_ids.size() == 0)
                    push_reply(ST_PROCEED, '0, 1'b1);
                while (waiting_ids.size() > 0)
                begin
                    id = waiting_ids.pop_front();
                    released_seen++;
                    push_reply(ST_RELEASED, id, waiting_ids.size() == 0);
                end
            end
        endcase
    endtask

    task automatic check_reply();
        sem_reply_t due;
        replies_checked++;
        if (replies_due.size() == 0)
        begin
            failures++;
            $error("unexpected reply: status %0d released_id %0d last %0d",
                   m_tuser, m_tdata, m_tlast);
        end
        else
        begin
            due = replies_due.pop_front();
            if (m_tuser !== due.status)
            begin
                failures++;
                $error("field status: expected %0d actual %0d", due.status, m_tuser);
            end
            if (m_tdata !== due.id)
            begin
                failures++;
                $error("field released_id: expected %0d actual %0d", due.id, m_tdata);
            end
            if (m_tlast !== due.last)
            begin
                failures++;
                $error("field last: expected %0d actual %0d", due.last, m_tlast);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_due.delete();
            waiting_ids.delete();
            sem_level       = '0;
            sem_closed      = 1'b0;
            reload_value    = '0;
            failures        = 0;
            replies_checked = 0;
            blocked_seen    = 0;
            full_seen       = 0;
            released_seen   = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_reply();
            if (s_tvalid && s_tready)
                predict_semaphore(cmd_t'(s_tuser), s_tdata);
            if (cfg_we)
                reload_value = cfg_wdata;
            outstanding <= replies_due.size();
        end
    end

endmodule

FILE: test/tb.sv
// testbench top for counting_semaphore_fifo_waitq_core: clock, reset, command and config stimulus
// with bursty sending, receiver stalls and a watchdog; the checker module does all prediction
// depends on csem_pkg, csem_checker and the core rtl
`timescale 1ns / 1ps

module tb;
    import csem_pkg::*;

    localparam int RANDOM_ITEMS = 140;
    localparam int QUIET_LIMIT  = 2000;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;    // thread_id[7:0]
    logic [1:0]       s_tuser   = '0;    // cmd[1:0]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;           // released_id[7:0]
    logic [2:0]       m_tuser;           // status[2:0]
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    int outstanding;
    int failures;
    int replies_checked;
    int blocked_seen;
    int full_seen;
    int released_seen;

    int commands_sent  = 0;
    int config_writes  = 0;
    int burst_left     = 0;
    int quiet_cycles   = 0;
    int ready_mode     = 0;
    int ready_mode_left = 0;
    int ready_tick     = 0;

    counting_semaphore_fifo_waitq_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    csem_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .outstanding     (outstanding),
        .failures        (failures),
        .replies_checked (replies_checked),
        .blocked_seen    (blocked_seen),
        .full_seen       (full_seen),
        .released_seen   (released_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls: modes from always ready to a fixed duty pattern
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(20, 80);
        end
        else
            ready_mode_left <= ready_mode_left - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (ready_tick % 8 >= 3);
        endcase
        ready_tick <= ready_tick + 1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_cmd(input cmd_t op, input logic [7:0] tid);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= tid;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        commands_sent++;
    endtask

    task automatic drain_replies();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [CFG_W-1:0] value);
        drain_replies();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        config_writes++;
    endtask

    task automatic run_episode();
        int kind;
        int len;
        int pick;
        int sel;
        logic [CFG_W-1:0] reload;
        kind = $urandom_range(0, 9);
        sel  = $urandom_range(0, 9);
        if (kind >= 6 && kind <= 7)
            reload = CFG_W'($urandom_range(0, 2));
        else if (sel == 0)
            reload = 16'hFFFF;
        else if (sel == 1)
            reload = 16'hFFFE;
        else if (sel == 2)
            reload = CFG_W'($urandom_range(0, 65535));
        else
            reload = CFG_W'($urandom_range(0, 3));
        write_initial_count(reload);
        send_cmd(CMD_OPEN, 8'($urandom_range(0, 255)));
        len = $urandom_range(10, 30);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (kind >= 8)
                send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (kind >= 6)
                send_cmd(pick < 85 ? CMD_WAIT : CMD_SIGNAL, 8'($urandom_range(0, 255)));
            else if (pick < 50)
                send_cmd(CMD_WAIT, 8'($urandom_range(0, 255)));
            else if (pick < 95)
                send_cmd(CMD_SIGNAL, 8'($urandom_range(0, 255)));
            else if (pick < 98)
                send_cmd(CMD_CLOSE, 8'($urandom_range(0, 255)));
            else
                send_cmd(CMD_OPEN, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 1)
            send_cmd(CMD_CLOSE, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int directed_count;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh after reset: count zero, open
        send_cmd(CMD_WAIT, 8'h00);
        send_cmd(CMD_SIGNAL, 8'hC3);
        send_cmd(CMD_CLOSE, 8'h00);
        send_cmd(CMD_WAIT, 8'hFF);
        send_cmd(CMD_SIGNAL, 8'h00);
        send_cmd(CMD_CLOSE, 8'hFF);

        // saturation at the top of the count
        write_initial_count(16'hFFFF);
        send_cmd(CMD_OPEN, 8'h00);
        send_cmd(CMD_SIGNAL, 8'h00);
        send_cmd(CMD_WAIT, 8'h3C);

        // fill the wait queue, refuse one more, then close releases all
        write_initial_count(16'h0000);
        send_cmd(CMD_OPEN, 8'h00);
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
            send_cmd(CMD_WAIT, i == 0 ? 8'hFF : (i == 1 ? 8'h00 : 8'($urandom_range(0, 255))));
        send_cmd(CMD_WAIT, 8'hAA);
        send_cmd(CMD_CLOSE, 8'h55);
        directed_count = commands_sent;

        while (commands_sent - directed_count < RANDOM_ITEMS)
            run_episode();

        drain_replies();
        repeat (8) @(posedge clk);

        $display("sent %0d commands over %0d initial_count settings, checked %0d replies",
                 commands_sent, config_writes, replies_checked);
        $display("waits blocked %0d, refused on full queue %0d, threads released %0d",
                 blocked_seen, full_seen, released_seen);
        if (failures == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
